// File: src/wwes_pkg.sv
// Shared types, constants and widths for the weighted wind estimate store.
package wwes_pkg;

   // Store size default
   localparam int DEPTH_DEF = 256;

   // Field widths
   localparam int NOW_W  = 17;
   localparam int ALT_W  = 15;
   localparam int WIND_W = 13;
   localparam int QUAL_W = 3;
   localparam int QWIN_W = 17;
   localparam int QALT_W = 14;

   // Port widths
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [QALT_W-1:0] DEF_ALT_RESET  = 14'd1000;
   localparam logic [QWIN_W-1:0] DEF_TIME_RESET = 17'd600;

   // Weighting and retry constants
   localparam int RETRY_T1   = 3600;
   localparam int RETRY_T2   = 7200;
   localparam int QUAL_MAX   = 5;
   localparam int QUAL_STEP  = 20;
   localparam int WA_SCALE   = 100;
   localparam int WT_SCALE   = 600;
   localparam int EVICT_BASE = 6;

   // Shared divider widths, sized for the largest store (4096 entries)
   localparam int DIV_NUM_W = 47;
   localparam int DIV_DEN_W = 37;
   localparam int DIV_QUO_W = 13;

   // Item kinds on the request tuser bit
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Register select on address bit 2
   localparam logic CSR_SEL_ALT  = 1'b0;
   localparam logic CSR_SEL_TIME = 1'b1;

   typedef struct packed {
      logic signed [ALT_W-1:0]  alt;
      logic signed [WIND_W-1:0] east;
      logic signed [WIND_W-1:0] north;
      logic [QUAL_W-1:0]        qual;
      logic [NOW_W-1:0]         stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                     mode;
      logic [NOW_W-1:0]         now;
      logic signed [ALT_W-1:0]  alt;
      logic signed [WIND_W-1:0] east;
      logic signed [WIND_W-1:0] north;
      logic [QUAL_W-1:0]        qual;
      logic [QWIN_W-1:0]        qwin;
      logic [QALT_W-1:0]        qalt;
   } item_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_DEN_W-1:0] den;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EV_RD, ST_EV_CMP,
      ST_DEL_RD, ST_DEL_WR,
      ST_INS_RD, ST_INS_CMP, ST_INS_WR0,
      ST_P_SQR, ST_P_SQT,
      ST_E_RD, ST_E_LD, ST_E_CHK,
      ST_E_M1, ST_E_M2, ST_E_M3,
      ST_E_DA, ST_E_DAW, ST_E_DT, ST_E_DTW,
      ST_E_W1, ST_E_W2, ST_E_PE, ST_E_PN, ST_E_ACC,
      ST_P_END,
      ST_M_E, ST_M_EW, ST_M_N, ST_M_NW,
      ST_OUT
   } state_type;

endpackage

// File: src/wwes_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wwes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/wwes_div.sv
// Shared restoring divider, one quotient bit per cycle.
module wwes_div (
   input  logic                clock,
   input  logic                reset,
   input  wwes_pkg::div_req_type div_req,
   output wwes_pkg::div_rsp_type div_rsp
);
   import wwes_pkg::*;

   localparam int CMP_W  = DIV_DEN_W + DIV_QUO_W;
   localparam int STEP_W = $clog2(DIV_QUO_W + 1);

   logic [CMP_W-1:0]     rem_ff, rem_in;
   logic [CMP_W-1:0]     dsh_ff, dsh_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // Load on start, then subtract the shifted divisor where it fits
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = CMP_W'(div_req.num);
         dsh_in  = CMP_W'(div_req.den) << (DIV_QUO_W - 1);
         den_in  = div_req.den;
         quo_in  = '0;
         step_in = STEP_W'(DIV_QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[DIV_QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[DIV_QUO_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff[DIV_DEN_W-1:0];
   assign div_rsp.den  = den_ff;

endmodule

// File: src/weighted_wind_estimate_store.sv
// Top level: altitude-sorted wind store with weighted mean queries.
//
//  channel  | group    | kind      | contents
//  ---------+----------+-----------+------------------------------------------
//  req      | slave    | stream    | one add or query transaction
//  rsp      | master   | stream    | one result per query, none per add
//  csr      | slave    | APB-style | default altitude and time windows
//
// An add scans the store for eviction only when full, shifts the tail down
// after an eviction and walks back from the top to insert. A query runs up
// to three passes; each pass checks every entry against the windows and is
// bound, for entries inside, by the shared 13-step divider (two divides per
// entry inside the windows, two for the mean). Reset empties the store at
// once (entry count cleared, no memory sweep) and loads the window defaults.
// A waiting result sits in the output register; the next transaction is
// taken meanwhile, and a query stalls at its end only while the previous
// result is still untaken.
module weighted_wind_estimate_store #(
   parameter int DEPTH = wwes_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_s, altitude_m, wind_east, wind_north, quality, query_window_s,
   // query_alt_range_m, zero fill
   input  logic [wwes_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mean_east, mean_north, zero fill
   output logic [wwes_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // valid_res
   output logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wwes_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wwes_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wwes_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import wwes_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int W_W   = 21;
   localparam int PW    = 34;
   localparam int SE_W  = PW + AW;
   localparam int TOT_W = W_W + AW;

   // Control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [1:0]        pass_ff, pass_in;
   logic [QALT_W-1:0] def_alt_ff, def_alt_in;
   logic [QWIN_W-1:0] def_time_ff, def_time_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   item_type                 it_ff, it_in;
   logic [AW-1:0]            found_ff, found_in;
   logic signed [22:0]       best_ff, best_in;
   logic [QWIN_W-1:0]        win_t_ff, win_t_in;
   logic [QALT_W-1:0]        win_r_ff, win_r_in;
   logic [27:0]              rr_ff, rr_in;
   logic [33:0]              tt_ff, tt_in;
   logic [15:0]              ad_ff, ad_in;
   logic [NOW_W-1:0]         dt_ff, dt_in;
   logic signed [WIND_W-1:0] e_east_ff, e_east_in;
   logic signed [WIND_W-1:0] e_north_ff, e_north_in;
   logic [QUAL_W-1:0]        e_qual_ff, e_qual_in;
   logic [25:0]              a2_ff, a2_in;
   logic [33:0]              dt2_ff, dt2_in;
   logic [33:0]              tp_ff, tp_in;
   logic [6:0]               wa_ff, wa_in;
   logic [7:0]               wt_ff, wt_in;
   logic [13:0]              wqa_ff, wqa_in;
   logic [W_W-1:0]           w_ff, w_in;
   logic signed [PW-1:0]     pe_ff, pe_in;
   logic signed [PW-1:0]     pn_ff, pn_in;
   logic signed [SE_W-1:0]   se_ff, se_in;
   logic signed [SE_W-1:0]   sn_ff, sn_in;
   logic [TOT_W-1:0]         tot_ff, tot_in;
   logic signed [WIND_W-1:0] res_east_ff, res_east_in;
   logic signed [WIND_W-1:0] res_north_ff, res_north_in;
   logic                     res_flag_ff, res_flag_in;
   logic signed [WIND_W-1:0] rsp_east_ff, rsp_east_in;
   logic signed [WIND_W-1:0] rsp_north_ff, rsp_north_in;
   logic                     rsp_flag_ff, rsp_flag_in;

   // Memory and divider hookup
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   entry_type          rd_entry, new_entry;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Shared conditions
   item_type           req_item;
   logic               req_acc, full, last_entry, in_window, out_free, retry_ok;
   logic               ev_last, ev_take, del_last, ins_greater, idx_zero;
   logic [AW-1:0]      found_nx;
   logic signed [4:0]  ev_q;
   logic signed [17:0] ev_dt;
   logic signed [22:0] ev_score;
   logic signed [15:0] alt_d;
   logic signed [17:0] t_d;
   logic [2:0]         q_sat;
   logic [6:0]         wq;
   logic [SE_W-1:0]    mag_e, mag_n;
   logic [27:0]        wa_base;
   logic               csr_we;

   function automatic logic [DIV_QUO_W-1:0] round_even(input div_rsp_type r);
      logic up;
      up = ({r.rem, 1'b0} > {1'b0, r.den}) ||
           (({r.rem, 1'b0} == {1'b0, r.den}) && r.quot[0]);
      return r.quot + DIV_QUO_W'(up);
   endfunction

   wwes_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wwes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Unpack the request transaction
   assign req_item.mode  = req_tuser;
   assign req_item.now   = req_tdata[16:0];
   assign req_item.alt   = req_tdata[31:17];
   assign req_item.east  = req_tdata[44:32];
   assign req_item.north = req_tdata[57:45];
   assign req_item.qual  = req_tdata[60:58];
   assign req_item.qwin  = req_tdata[77:61];
   assign req_item.qalt  = req_tdata[91:78];

   assign rd_entry        = entry_type'(ram_rdata);
   assign new_entry.alt   = it_ff.alt;
   assign new_entry.east  = it_ff.east;
   assign new_entry.north = it_ff.north;
   assign new_entry.qual  = it_ff.qual;
   assign new_entry.stamp = it_ff.now;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign last_entry = (idx_ff == AW'(count_ff - CW'(1)));
   assign idx_zero   = (idx_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign retry_ok   = (it_ff.qwin < QWIN_W'(RETRY_T1)) && (pass_ff != 2'd2);
   assign in_window  = ({ad_ff, 1'b0} < 17'(win_r_ff)) && (dt_ff < win_t_ff);

   // Eviction score: (6 - quality) * age, highest index wins a tie
   assign ev_q     = 5'(EVICT_BASE) - $signed({2'b00, rd_entry.qual});
   assign ev_dt    = $signed({1'b0, it_ff.now}) - $signed({1'b0, rd_entry.stamp});
   assign ev_score = 23'(ev_q) * 23'(ev_dt);
   assign ev_take  = (ev_score > 0) && (ev_score >= best_ff);
   assign found_nx = ev_take ? idx_ff : found_ff;
   assign ev_last  = (idx_ff == AW'(DEPTH - 1));
   assign del_last = (idx_ff == AW'(DEPTH - 2));
   assign ins_greater = (rd_entry.alt > it_ff.alt);

   // Per-entry distances for the query walk
   assign alt_d = 16'(it_ff.alt) - 16'(rd_entry.alt);
   assign t_d   = $signed({1'b0, it_ff.now}) - $signed({1'b0, rd_entry.stamp});
   assign q_sat = (e_qual_ff > 3'(QUAL_MAX)) ? 3'(QUAL_MAX) : e_qual_ff;
   assign wq    = 7'(q_sat) * 7'(QUAL_STEP);
   assign wa_base = rr_ff - {a2_ff, 2'b00};
   assign mag_e = se_ff[SE_W-1] ? SE_W'(-se_ff) : SE_W'(se_ff);
   assign mag_n = sn_ff[SE_W-1] ? SE_W'(-sn_ff) : SE_W'(sn_ff);

   assign csr_we = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_item.mode == MODE_ADD) begin
                  if (full) begin
                     state_in = ST_EV_RD;
                  end else if (count_ff == '0) begin
                     state_in = ST_INS_WR0;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_P_SQR;
               end
            end
         end
         ST_EV_RD: state_in = ST_EV_CMP;
         ST_EV_CMP: begin
            if (ev_last) begin
               state_in = (found_nx == AW'(DEPTH - 1)) ? ST_INS_RD : ST_DEL_RD;
            end else begin
               state_in = ST_EV_RD;
            end
         end
         ST_DEL_RD: state_in = ST_DEL_WR;
         ST_DEL_WR: state_in = del_last ? ST_INS_RD : ST_DEL_RD;
         ST_INS_RD: state_in = ST_INS_CMP;
         ST_INS_CMP: begin
            if (ins_greater) begin
               state_in = idx_zero ? ST_INS_WR0 : ST_INS_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INS_WR0: state_in = ST_IDLE;
         ST_P_SQR:   state_in = ST_P_SQT;
         ST_P_SQT:   state_in = ST_E_RD;
         ST_E_RD:    state_in = ST_E_LD;
         ST_E_LD:    state_in = ST_E_CHK;
         ST_E_CHK: begin
            if (in_window) begin
               state_in = ST_E_M1;
            end else begin
               state_in = last_entry ? ST_P_END : ST_E_RD;
            end
         end
         ST_E_M1:  state_in = ST_E_M2;
         ST_E_M2:  state_in = ST_E_M3;
         ST_E_M3:  state_in = ST_E_DA;
         ST_E_DA:  state_in = ST_E_DAW;
         ST_E_DAW: state_in = div_rsp.done ? ST_E_DT : ST_E_DAW;
         ST_E_DT:  state_in = ST_E_DTW;
         ST_E_DTW: state_in = div_rsp.done ? ST_E_W1 : ST_E_DTW;
         ST_E_W1:  state_in = ST_E_W2;
         ST_E_W2:  state_in = ST_E_PE;
         ST_E_PE:  state_in = ST_E_PN;
         ST_E_PN:  state_in = ST_E_ACC;
         ST_E_ACC: state_in = last_entry ? ST_P_END : ST_E_RD;
         ST_P_END: begin
            if (tot_ff != '0) begin
               state_in = ST_M_E;
            end else if (retry_ok) begin
               state_in = ST_P_SQR;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_M_E:  state_in = ST_M_EW;
         ST_M_EW: state_in = div_rsp.done ? ST_M_N : ST_M_EW;
         ST_M_N:  state_in = ST_M_NW;
         ST_M_NW: state_in = div_rsp.done ? ST_OUT : ST_M_NW;
         ST_OUT:  state_in = out_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory and divider control
   always_comb begin
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = idx_ff;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         ST_DEL_RD: ram_raddr = AW'(idx_ff + AW'(1));
         ST_DEL_WR: begin
            ram_we = 1'b1;
         end
         ST_INS_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_ff + AW'(1));
            ram_wdata = ins_greater ? ram_rdata : ENTRY_W'(new_entry);
         end
         ST_INS_WR0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = ENTRY_W'(new_entry);
         end
         ST_E_DA: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(wa_base) * DIV_NUM_W'(WA_SCALE);
            div_req.den   = DIV_DEN_W'(rr_ff) + DIV_DEN_W'({a2_ff, 2'b00});
         end
         ST_E_DT: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(tp_ff) * DIV_NUM_W'(WT_SCALE);
            div_req.den   = DIV_DEN_W'({dt2_ff, 2'b00}) + DIV_DEN_W'({tt_ff, 1'b0}) +
                            DIV_DEN_W'(tt_ff);
         end
         ST_M_E: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({mag_e, 1'b0}) + DIV_NUM_W'(tot_ff);
            div_req.den   = DIV_DEN_W'({tot_ff, 1'b0});
         end
         ST_M_N: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({mag_n, 1'b0}) + DIV_NUM_W'(tot_ff);
            div_req.den   = DIV_DEN_W'({tot_ff, 1'b0});
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Datapath and counters
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      it_in        = it_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      win_t_in     = win_t_ff;
      win_r_in     = win_r_ff;
      rr_in        = rr_ff;
      tt_in        = tt_ff;
      ad_in        = ad_ff;
      dt_in        = dt_ff;
      e_east_in    = e_east_ff;
      e_north_in   = e_north_ff;
      e_qual_in    = e_qual_ff;
      a2_in        = a2_ff;
      dt2_in       = dt2_ff;
      tp_in        = tp_ff;
      wa_in        = wa_ff;
      wt_in        = wt_ff;
      wqa_in       = wqa_ff;
      w_in         = w_ff;
      pe_in        = pe_ff;
      pn_in        = pn_ff;
      se_in        = se_ff;
      sn_in        = sn_ff;
      tot_in       = tot_ff;
      res_east_in  = res_east_ff;
      res_north_in = res_north_ff;
      res_flag_in  = res_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               it_in        = req_item;
               found_in     = AW'(DEPTH - 1);
               best_in      = '0;
               idx_in       = full ? '0 : AW'(count_ff - CW'(1));
               win_t_in     = (req_item.qwin != '0) ? req_item.qwin : def_time_ff;
               win_r_in     = (req_item.qalt != '0) ? req_item.qalt : def_alt_ff;
               pass_in      = '0;
               se_in        = '0;
               sn_in        = '0;
               tot_in       = '0;
               res_east_in  = '0;
               res_north_in = '0;
               res_flag_in  = 1'b0;
            end
         end
         ST_EV_CMP: begin
            if (ev_take) begin
               best_in = ev_score;
            end
            found_in = found_nx;
            if (ev_last) begin
               if (found_nx == AW'(DEPTH - 1)) begin
                  count_in = CW'(DEPTH - 1);
                  idx_in   = AW'(DEPTH - 2);
               end else begin
                  idx_in = found_nx;
               end
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_DEL_WR: begin
            if (del_last) begin
               count_in = CW'(DEPTH - 1);
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_INS_CMP: begin
            if (ins_greater) begin
               if (!idx_zero) begin
                  idx_in = idx_ff - AW'(1);
               end
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_INS_WR0: count_in = count_ff + CW'(1);
         ST_P_SQR: rr_in = 28'(win_r_ff) * 28'(win_r_ff);
         ST_P_SQT: begin
            tt_in  = 34'(win_t_ff) * 34'(win_t_ff);
            idx_in = '0;
         end
         ST_E_LD: begin
            ad_in      = alt_d[15] ? 16'(-alt_d) : 16'(alt_d);
            dt_in      = t_d[17] ? NOW_W'(-t_d) : NOW_W'(t_d);
            e_east_in  = rd_entry.east;
            e_north_in = rd_entry.north;
            e_qual_in  = rd_entry.qual;
         end
         ST_E_CHK: begin
            if (!in_window && !last_entry) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_E_M1: a2_in  = 26'(32'(ad_ff) * 32'(ad_ff));
         ST_E_M2: dt2_in = 34'(dt_ff) * 34'(dt_ff);
         ST_E_M3: tp_in  = 34'(win_t_ff) * 34'(win_t_ff - dt_ff);
         ST_E_DAW: begin
            if (div_rsp.done) begin
               wa_in = 7'(round_even(div_rsp));
            end
         end
         ST_E_DTW: begin
            if (div_rsp.done) begin
               wt_in = 8'(round_even(div_rsp));
            end
         end
         ST_E_W1: wqa_in = 14'(wq) * 14'(wa_ff);
         ST_E_W2: w_in   = W_W'(22'(wqa_ff) * 22'(wt_ff));
         ST_E_PE: pe_in  = 34'(e_east_ff) * $signed(34'({1'b0, w_ff}));
         ST_E_PN: pn_in  = 34'(e_north_ff) * $signed(34'({1'b0, w_ff}));
         ST_E_ACC: begin
            se_in  = se_ff + SE_W'(pe_ff);
            sn_in  = sn_ff + SE_W'(pn_ff);
            tot_in = tot_ff + TOT_W'(w_ff);
            if (!last_entry) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_P_END: begin
            if ((tot_ff == '0) && retry_ok) begin
               pass_in  = pass_ff + 2'd1;
               win_t_in = (pass_ff == 2'd0) ? QWIN_W'(RETRY_T1) : QWIN_W'(RETRY_T2);
               win_r_in = def_alt_ff;
               se_in    = '0;
               sn_in    = '0;
               tot_in   = '0;
            end
         end
         ST_M_EW: begin
            if (div_rsp.done) begin
               res_east_in = se_ff[SE_W-1] ? WIND_W'(-div_rsp.quot) : WIND_W'(div_rsp.quot);
            end
         end
         ST_M_NW: begin
            if (div_rsp.done) begin
               res_north_in = sn_ff[SE_W-1] ? WIND_W'(-div_rsp.quot) : WIND_W'(div_rsp.quot);
               res_flag_in  = 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Output register: drop on take, load when a result leaves the engine
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_east_in  = rsp_east_ff;
      rsp_north_in = rsp_north_ff;
      rsp_flag_in  = rsp_flag_ff;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_east_in  = res_east_ff;
         rsp_north_in = res_north_ff;
         rsp_flag_in  = res_flag_ff;
      end
   end

   // Configuration writes
   always_comb begin
      def_alt_in  = def_alt_ff;
      def_time_in = def_time_ff;
      if (csr_we) begin
         if (csr_paddr[2] == CSR_SEL_TIME) begin
            def_time_in = csr_pwdata[QWIN_W-1:0];
         end else begin
            def_alt_in = csr_pwdata[QALT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         def_alt_ff   <= DEF_ALT_RESET;
         def_time_ff  <= DEF_TIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         def_alt_ff   <= def_alt_in;
         def_time_ff  <= def_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      it_ff        <= it_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      win_t_ff     <= win_t_in;
      win_r_ff     <= win_r_in;
      rr_ff        <= rr_in;
      tt_ff        <= tt_in;
      ad_ff        <= ad_in;
      dt_ff        <= dt_in;
      e_east_ff    <= e_east_in;
      e_north_ff   <= e_north_in;
      e_qual_ff    <= e_qual_in;
      a2_ff        <= a2_in;
      dt2_ff       <= dt2_in;
      tp_ff        <= tp_in;
      wa_ff        <= wa_in;
      wt_ff        <= wt_in;
      wqa_ff       <= wqa_in;
      w_ff         <= w_in;
      pe_ff        <= pe_in;
      pn_ff        <= pn_in;
      se_ff        <= se_in;
      sn_ff        <= sn_in;
      tot_ff       <= tot_in;
      res_east_ff  <= res_east_in;
      res_north_ff <= res_north_in;
      res_flag_ff  <= res_flag_in;
      rsp_east_ff  <= rsp_east_in;
      rsp_north_ff <= rsp_north_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_north_ff, rsp_east_ff});
   assign rsp_tuser  = rsp_flag_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_ALT) ? CSR_DATA_W'(def_alt_ff) :
                                                       CSR_DATA_W'(def_time_ff);

endmodule

// File: dv/tb_weighted_wind_estimate_store.sv
// Testbench for the weighted wind estimate store: a self-checking mix of add and query streams.
module tb_weighted_wind_estimate_store;
   import wwes_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int SETTLE_CYC  = 3000;
   localparam int CSR_ALT_IDX  = 0;
   localparam int CSR_TIME_IDX = 1;

   typedef struct {
      logic signed [WIND_W-1:0] east;
      logic signed [WIND_W-1:0] north;
      logic                     valid;
   } wind_mean_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state
   entry_type           wind_store [DEPTH];
   int                  wind_count;
   longint              alt_win_cfg;
   longint              time_win_cfg;
   wind_mean_type       mean_q[$];
   int                  mismatch_cnt;
   int                  burst_left;
   int                  clock_now;

   weighted_wind_estimate_store u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Round n/d to nearest, ties to even
   function automatic longint div_round_even(longint n, longint d);
      longint q;
      longint r;
      q = n / d;
      r = n % d;
      if (2 * r > d || (2 * r == d && q[0]))
         q++;
      return q;
   endfunction

   // Round s/t to nearest, halves away from zero
   function automatic longint div_round_away(longint s, longint t);
      longint mag;
      longint q;
      mag = (s < 0) ? -s : s;
      q = (2 * mag + t) / (2 * t);
      return (s < 0) ? -q : q;
   endfunction

   // One weighting pass over the store; returns the total weight
   function automatic longint weigh_pass(longint alt, longint now, longint win_t,
                                         longint win_r, output longint sum_e,
                                         output longint sum_n);
      longint total;
      longint ad;
      longint dt;
      longint wq;
      longint wa;
      longint wt;
      longint w;
      longint q;
      total = 0;
      sum_e = 0;
      sum_n = 0;
      for (int i = 0; i < wind_count; i++) begin
         ad = alt - longint'(wind_store[i].alt);
         if (ad < 0) ad = -ad;
         dt = now - longint'(wind_store[i].stamp);
         if (dt < 0) dt = -dt;
         if (!(2 * ad < win_r) || !(dt < win_t))
            continue;
         q  = longint'(wind_store[i].qual);
         wq = (q > QUAL_MAX ? QUAL_MAX : q) * QUAL_STEP;
         wa = div_round_even(WA_SCALE * (win_r * win_r - 4 * ad * ad),
                             win_r * win_r + 4 * ad * ad);
         wt = div_round_even(WT_SCALE * win_t * (win_t - dt),
                             4 * dt * dt + 3 * win_t * win_t);
         w = wq * wa * wt;
         if (w == 0)
            continue;
         sum_e += longint'(wind_store[i].east) * w;
         sum_n += longint'(wind_store[i].north) * w;
         total += w;
      end
      return total;
   endfunction

   // Advance the predictor by one accepted transaction
   task automatic predict_item(item_type it);
      longint now;
      longint score;
      longint best;
      longint win_t;
      longint win_r;
      longint se;
      longint sn;
      longint total;
      int victim;
      int pos;
      wind_mean_type res;
      now = longint'(it.now);
      if (it.mode == MODE_ADD) begin
         if (wind_count >= DEPTH) begin
            best = 0;
            victim = DEPTH - 1;
            for (int i = DEPTH - 1; i >= 0; i--) begin
               score = (EVICT_BASE - longint'(wind_store[i].qual)) *
                       (now - longint'(wind_store[i].stamp));
               if (score > best) begin
                  best = score;
                  victim = i;
               end
            end
            for (int i = victim; i < DEPTH - 1; i++)
               wind_store[i] = wind_store[i + 1];
            wind_count = DEPTH - 1;
         end
         pos = 0;
         while (pos < wind_count && wind_store[pos].alt <= it.alt)
            pos++;
         for (int i = wind_count; i > pos; i--)
            wind_store[i] = wind_store[i - 1];
         wind_store[pos].alt   = it.alt;
         wind_store[pos].east  = it.east;
         wind_store[pos].north = it.north;
         wind_store[pos].qual  = it.qual;
         wind_store[pos].stamp = it.now;
         wind_count++;
      end else begin
         win_t = (it.qwin != 0) ? longint'(it.qwin) : time_win_cfg;
         win_r = (it.qalt != 0) ? longint'(it.qalt) : alt_win_cfg;
         total = 0;
         se = 0;
         sn = 0;
         if (wind_count > 0) begin
            total = weigh_pass(longint'(it.alt), now, win_t, win_r, se, sn);
            if (total <= 0 && it.qwin < RETRY_T1) begin
               total = weigh_pass(longint'(it.alt), now, RETRY_T1, alt_win_cfg, se, sn);
               if (total <= 0)
                  total = weigh_pass(longint'(it.alt), now, RETRY_T2, alt_win_cfg,
                                     se, sn);
            end
         end
         if (total > 0) begin
            res.east  = WIND_W'(div_round_away(se, total));
            res.north = WIND_W'(div_round_away(sn, total));
            res.valid = 1'b1;
         end else begin
            res.east  = '0;
            res.north = '0;
            res.valid = 1'b0;
         end
         mean_q.push_back(res);
      end
   endtask

   // Drive one transaction, in bursts with random gaps
   task automatic send_item(item_type it);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         if ($urandom_range(0, 3) != 0)
            repeat ($urandom_range(1, 15)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.mode;
      req_tdata  = {4'b0, it.qalt, it.qwin, it.qual, it.north, it.east, it.alt, it.now};
      do @(posedge clock); while (!req_tready);
      predict_item(it);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_add(int now, int alt, int east, int north, int qual);
      item_type it;
      it = '0;
      it.mode  = MODE_ADD;
      it.now   = NOW_W'(now);
      it.alt   = ALT_W'(alt);
      it.east  = WIND_W'(east);
      it.north = WIND_W'(north);
      it.qual  = QUAL_W'(qual);
      send_item(it);
   endtask

   task automatic send_query(int now, int alt, int qwin, int qalt);
      item_type it;
      it = '0;
      it.mode = MODE_QUERY;
      it.now  = NOW_W'(now);
      it.alt  = ALT_W'(alt);
      it.qwin = QWIN_W'(qwin);
      it.qalt = QALT_W'(qalt);
      send_item(it);
   endtask

   // Drain, let a trailing add finish, then write one register
   task automatic write_csr(int idx, int value);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (mean_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
      csr_psel   = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr  = CSR_ADDR_W'(idx * 4);
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (idx == CSR_ALT_IDX)
         alt_win_cfg = longint'(value & 32'h3FFF);
      else
         time_win_cfg = longint'(value & 32'h1FFFF);
   endtask

   // Empty store answers invalid without retries
   task automatic test_empty_query();
      send_query(0, 0, 0, 0);
      send_query(86399, 16383, 86399, 16383);
   endtask

   // Field extremes, every quality, equal altitudes, retry paths
   task automatic test_field_extremes();
      send_add(0, -1024, -4096, 4095, 0);
      send_add(86399, 16383, 4095, -4096, 7);
      send_add(1000, 500, 100, -100, 5);
      send_add(1000, 500, -300, 300, 6);
      send_add(1100, 520, 1234, -777, 3);
      send_add(1200, 480, -2000, 50, 1);
      send_add(1300, 500, 7, 8, 2);
      send_add(1400, 510, 4095, 4095, 4);
      send_query(1300, 500, 0, 0);
      send_query(1300, 500, 4000, 200);
      send_query(5000, 500, 100, 100);
      send_query(86399, 16383, 86399, 16383);
      send_query(0, -1024, 1, 1);
      send_query(60000, 500, 3599, 0);
   endtask

   // Default windows at their extremes, including zero
   task automatic test_window_defaults();
      write_csr(CSR_ALT_IDX, 16383);
      write_csr(CSR_TIME_IDX, 86399);
      send_query(1300, 3000, 0, 0);
      write_csr(CSR_ALT_IDX, 1);
      write_csr(CSR_TIME_IDX, 1);
      send_query(1000, 500, 0, 0);
      send_query(1000, 501, 0, 0);
      write_csr(CSR_ALT_IDX, 0);
      write_csr(CSR_TIME_IDX, 0);
      send_query(1300, 500, 0, 0);
      write_csr(CSR_ALT_IDX, 2000);
      write_csr(CSR_TIME_IDX, 900);
   endtask

   // Clustered adds fill the store past full; queries mixed in, some noise
   task automatic test_random_mix(int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         clock_now += $urandom_range(0, 40);
         if (clock_now > 86399) clock_now = 86399;
         sel = $urandom_range(0, 99);
         if (sel < 90)
            send_add(clock_now, $urandom_range(300, 2500), $urandom_range(0, 8191) - 4096,
                     $urandom_range(0, 8191) - 4096, $urandom_range(0, 7));
         else if (sel < 97)
            send_query(clock_now - $urandom_range(0, 300), $urandom_range(300, 2500),
                       ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7200),
                       ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16383));
         else if (sel < 98)
            send_add($urandom_range(0, 86399), $urandom_range(0, 17407) - 1024,
                     $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                     $urandom_range(0, 7));
         else
            send_query($urandom_range(0, 86399), $urandom_range(0, 17407) - 1024,
                       $urandom_range(0, 86399), $urandom_range(0, 16383));
         if (k == count / 2) begin
            write_csr(CSR_ALT_IDX, $urandom_range(200, 4000));
            write_csr(CSR_TIME_IDX, $urandom_range(300, 5000));
         end
      end
   endtask

   // Receiver stall pattern: free-running stretches and random stalls
   int stall_phase;
   initial begin
      rsp_tready  = 1'b0;
      stall_phase = 0;
      forever begin
         @(negedge clock);
         if (stall_phase == 0)
            stall_phase = $urandom_range(1, 60);
         stall_phase--;
         if (stall_phase > 30)
            rsp_tready = 1'b1;
         else
            rsp_tready = ($urandom_range(0, 2) != 0);
      end
   end

   // Compare each result transaction with the oldest expected mean
   always @(posedge clock) begin
      wind_mean_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mean_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected result: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            exp_r = mean_q.pop_front();
            if (rsp_tdata[12:0] !== exp_r.east || rsp_tdata[25:13] !== exp_r.north ||
                rsp_tdata[31:26] !== '0 || rsp_tuser !== exp_r.valid) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mean mismatch: exp e=%0d n=%0d v=%b got e=%0d n=%0d v=%b",
                           exp_r.east, exp_r.north, exp_r.valid,
                           $signed(rsp_tdata[12:0]), $signed(rsp_tdata[25:13]), rsp_tuser);
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      mismatch_cnt = 0;
      burst_left   = 0;
      wind_count   = 0;
      clock_now    = 20000;
      alt_win_cfg  = DEF_ALT_RESET;
      time_win_cfg = DEF_TIME_RESET;
      foreach (wind_store[i]) wind_store[i] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_empty_query();
      test_field_extremes();
      test_window_defaults();
      test_random_mix(290);

      req_tvalid = 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
